FILE: sv/bcd_calendar_clock_registers_defines.svh
// Assertion macros for the BCD calendar clock register block.
`ifndef BCD_CALENDAR_CLOCK_REGISTERS_DEFINES_SVH
`define BCD_CALENDAR_CLOCK_REGISTERS_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define BCR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("bcd clock assertion failed");
// Check that a condition in one cycle leads to another in the next.
`define BCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcd clock next-cycle assertion failed");
`else
`define BCR_ASSERT(label, prop)
`define BCR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/bcdcr_pkg.sv
// Types and constants shared by the BCD calendar clock register block.
package bcdcr_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef logic [3:0] t_nibble;

    localparam int TIME_DEPTH  = 13;
    localparam int ALARM_DEPTH = 7;

    // Bank 0 digit positions
    localparam logic [3:0] DIG_S1   = 4'd0;
    localparam logic [3:0] DIG_S10  = 4'd1;
    localparam logic [3:0] DIG_M1   = 4'd2;
    localparam logic [3:0] DIG_M10  = 4'd3;
    localparam logic [3:0] DIG_H1   = 4'd4;
    localparam logic [3:0] DIG_H10  = 4'd5;
    localparam logic [3:0] DIG_DOW  = 4'd6;
    localparam logic [3:0] DIG_D1   = 4'd7;
    localparam logic [3:0] DIG_D10  = 4'd8;
    localparam logic [3:0] DIG_MO1  = 4'd9;
    localparam logic [3:0] DIG_MO10 = 4'd10;
    localparam logic [3:0] DIG_Y1   = 4'd11;
    localparam logic [3:0] DIG_Y10  = 4'd12;

    // Bank 1 and shared register offsets
    localparam logic [3:0] REG_CLKOUT    = 4'd0;
    localparam logic [3:0] REG_ADJUST    = 4'd1;
    localparam logic [3:0] REG_ALARM_LO  = 4'd2;
    localparam logic [3:0] REG_ALARM_HI  = 4'd8;
    localparam logic [3:0] REG_LEAP      = 4'd11;
    localparam logic [3:0] REG_MODE      = 4'd13;

    localparam int MODE_BANK  = 0;
    localparam int MODE_TIMER = 3;
    localparam logic [3:0] MODE_RESET = 4'h8;

endpackage

FILE: sv/bcd_calendar_clock_registers.sv
// Banked BCD real-time clock and calendar register block.
// A result passes through the input register, then the result register; throughput is one item
// per cycle while the output does not stall, set by the single state update pass between the
// two registers. Stalls on the output hold the input stage.
// Reset (synchronous, active low) empties both stages and sets the clock to
// day 1 of month 1, mode 8 (timer on, bank 0), all other state zero.
`include "bcd_calendar_clock_registers_defines.svh"

module bcd_calendar_clock_registers #(
    parameter int PULSES_PER_SECOND = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] register_index, [7:4] write_data
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [3:0] read_data, [4] pulse_16hz, [5] pulse_1hz, [7:6] zero
);
    import bcdcr_pkg::*;

    localparam logic [4:0] P_FULL = 5'(PULSES_PER_SECOND);
    localparam logic [4:0] P_HALF = 5'(PULSES_PER_SECOND / 2);

    // Input stage
    logic    r_in_valid;
    t_op     r_in_op;
    t_nibble r_in_idx;
    t_nibble r_in_data;

    // Output stage
    logic    r_out_valid;
    t_nibble r_out_rd;
    logic    r_out_fast;
    logic    r_out_slow;

    // Clock state
    t_nibble    r_time  [TIME_DEPTH];
    t_nibble    r_alarm [ALARM_DEPTH];
    logic [2:0] r_cos;
    t_nibble    r_mode;
    logic [1:0] r_leap;
    logic [4:0] r_cnt;
    logic       r_fast;
    logic       r_slow;

    t_nibble    n_time  [TIME_DEPTH];
    t_nibble    n_alarm [ALARM_DEPTH];
    logic [2:0] n_cos;
    t_nibble    n_mode;
    logic [1:0] n_leap;
    logic [4:0] n_cnt;
    logic       n_fast;
    logic       n_slow;
    t_nibble    n_rd;

    logic    adv;
    logic    fire;
    t_nibble rd_val;
    logic    in_time;
    logic    in_alarm;

    assign adv           = !r_out_valid || m_axis_tready;
    assign fire          = adv && r_in_valid;
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_slow, r_out_fast, r_out_rd};

    assign in_time  = r_in_idx < 4'(TIME_DEPTH);
    assign in_alarm = (r_in_idx >= REG_ALARM_LO) && (r_in_idx <= REG_ALARM_HI);

    // Register read mux
    always_comb begin
        rd_val = '0;
        priority if (r_in_idx == REG_MODE) begin
            rd_val = r_mode;
        end else if (!r_mode[MODE_BANK]) begin
            if (in_time) rd_val = r_time[r_in_idx];
        end else if (r_in_idx == REG_CLKOUT) begin
            rd_val = {1'b0, r_cos};
        end else if (in_alarm) begin
            rd_val = r_alarm[3'(r_in_idx - REG_ALARM_LO)];
        end else if (r_in_idx == REG_LEAP) begin
            rd_val = {2'b00, r_leap};
        end else begin
            rd_val = '0;
        end
    end

    // Single pass: operation, then the carry cascade
    always_comb begin
        logic [4:0] v;
        logic [4:0] h1p;
        logic [8:0] d;
        logic [7:0] mon;
        logic [8:0] last;
        logic       has_last;
        logic       min_inc;
        logic       day_inc;
        logic       mon_inc;
        logic       yr_inc;

        n_time   = r_time;
        n_alarm  = r_alarm;
        n_cos    = r_cos;
        n_mode   = r_mode;
        n_leap   = r_leap;
        n_cnt    = r_cnt;
        n_fast   = r_fast;
        n_slow   = r_slow;
        n_rd     = '0;
        min_inc  = 1'b0;
        day_inc  = 1'b0;
        mon_inc  = 1'b0;
        yr_inc   = 1'b0;
        v        = '0;
        h1p      = '0;
        d        = '0;
        mon      = '0;
        last     = '0;
        has_last = 1'b0;

        if (fire) begin
            unique case (r_in_op)
                OP_READ: begin
                    n_rd = rd_val;
                end
                OP_WRITE: begin
                    priority if (r_in_idx == REG_MODE) begin
                        n_mode = r_in_data;
                    end else if (!r_mode[MODE_BANK]) begin
                        if (in_time) n_time[r_in_idx] = r_in_data;
                    end else if (r_in_idx == REG_CLKOUT) begin
                        n_cos = r_in_data[2:0];
                    end else if (r_in_idx == REG_ADJUST) begin
                        // round to the nearest minute
                        min_inc         = r_time[DIG_S10] >= 4'd3;
                        n_time[DIG_S1]  = '0;
                        n_time[DIG_S10] = '0;
                    end else if (in_alarm) begin
                        n_alarm[3'(r_in_idx - REG_ALARM_LO)] = r_in_data;
                    end else if (r_in_idx == REG_LEAP) begin
                        n_leap = r_in_data[1:0];
                    end else begin
                        // unused offset: drop the write
                    end
                end
                OP_TICK: begin
                    if (!r_fast) begin
                        n_fast = 1'b1;
                        n_cnt  = r_cnt + 5'd1;
                    end else begin
                        n_fast = 1'b0;
                    end
                    if (n_cnt == P_HALF) n_slow = 1'b0;
                    if (n_cnt == P_FULL) begin
                        n_cnt  = '0;
                        n_slow = 1'b1;
                        if (r_mode[MODE_TIMER]) begin
                            v = {1'b0, r_time[DIG_S1]} + 5'd1;
                            if (v < 5'd10) begin
                                n_time[DIG_S1] = v[3:0];
                            end else begin
                                n_time[DIG_S1] = '0;
                                v = {1'b0, r_time[DIG_S10]} + 5'd1;
                                if (v < 5'd6) begin
                                    n_time[DIG_S10] = v[3:0];
                                end else begin
                                    n_time[DIG_S10] = '0;
                                    min_inc = 1'b1;
                                end
                            end
                        end
                    end
                end
                OP_NONE: begin
                end
            endcase
        end

        // Minutes and hours
        if (min_inc) begin
            v = {1'b0, r_time[DIG_M1]} + 5'd1;
            if (v < 5'd10) begin
                n_time[DIG_M1] = v[3:0];
            end else begin
                n_time[DIG_M1] = '0;
                v = {1'b0, r_time[DIG_M10]} + 5'd1;
                if (v < 5'd6) begin
                    n_time[DIG_M10] = v[3:0];
                end else begin
                    n_time[DIG_M10] = '0;
                    h1p = {1'b0, r_time[DIG_H1]} + 5'd1;
                    if ((h1p < 5'd10 && r_time[DIG_H10] < 4'd2) ||
                        (r_time[DIG_H10] < 4'd3 && h1p < 5'd4)) begin
                        n_time[DIG_H1] = h1p[3:0];
                    end else begin
                        n_time[DIG_H1] = '0;
                        v = {1'b0, r_time[DIG_H10]} + 5'd1;
                        if (v < 5'd3) begin
                            n_time[DIG_H10] = v[3:0];
                        end else begin
                            n_time[DIG_H10] = '0;
                            day_inc = 1'b1;
                        end
                    end
                end
            end
        end

        // Day of week and day of month
        if (day_inc) begin
            v = {1'b0, r_time[DIG_DOW]} + 5'd1;
            n_time[DIG_DOW] = (v >= 5'd7) ? 4'd0 : v[3:0];
            d = {1'b0, r_time[DIG_D10], r_time[DIG_D1]} + 9'd1;
            if (d[3:0] >= 4'd10) begin
                d = {d[8:4], 4'd0} + 9'h010;
            end
            n_time[DIG_D1]  = d[3:0];
            n_time[DIG_D10] = d[7:4];
            mon = {r_time[DIG_MO10], r_time[DIG_MO1]};
            has_last = 1'b1;
            unique case (mon)
                8'h01, 8'h03, 8'h05, 8'h07, 8'h08, 8'h10, 8'h12: last = 9'h031;
                8'h04, 8'h06, 8'h09, 8'h11:                       last = 9'h030;
                8'h02: last = (r_leap == 2'd0) ? 9'h029 : 9'h028;
                default: has_last = 1'b0;   // not a month: never ends
            endcase
            if (has_last && d > last) begin
                n_time[DIG_D1]  = 4'd1;
                n_time[DIG_D10] = 4'd0;
                mon_inc = 1'b1;
            end
        end

        // Month
        if (mon_inc) begin
            v = {1'b0, r_time[DIG_MO1]} + 5'd1;
            if ((v < 5'd10 && r_time[DIG_MO10] < 4'd1) ||
                (v < 5'd3 && r_time[DIG_MO10] < 4'd2)) begin
                n_time[DIG_MO1] = v[3:0];
            end else if (r_time[DIG_MO10] < 4'd1) begin
                n_time[DIG_MO1]  = 4'd0;
                n_time[DIG_MO10] = 4'd1;
            end else begin
                n_time[DIG_MO1]  = 4'd1;
                n_time[DIG_MO10] = 4'd0;
                yr_inc = 1'b1;
            end
        end

        // Year and leap counter
        if (yr_inc) begin
            n_leap = r_leap + 2'd1;
            v = {1'b0, r_time[DIG_Y1]} + 5'd1;
            if (v < 5'd10) begin
                n_time[DIG_Y1] = v[3:0];
            end else begin
                n_time[DIG_Y1] = '0;
                v = {1'b0, r_time[DIG_Y10]} + 5'd1;
                n_time[DIG_Y10] = (v < 5'd10) ? v[3:0] : 4'd0;
            end
        end
    end

    // Handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid  <= s_axis_tvalid;
            if (adv)           r_out_valid <= r_in_valid;
        end
    end

    // Payload: capture input, load result
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_idx  <= s_axis_tdata[3:0];
            r_in_data <= s_axis_tdata[7:4];
        end
        if (fire) begin
            r_out_rd   <= n_rd;
            r_out_fast <= n_fast;
            r_out_slow <= n_slow;
        end
    end

    // Clock state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // day and month start at one
            for (int i = 0; i < TIME_DEPTH; i++)
                r_time[i] <= (4'(i) == DIG_D1 || 4'(i) == DIG_MO1) ? 4'd1 : 4'd0;
            for (int i = 0; i < ALARM_DEPTH; i++) r_alarm[i] <= '0;
            r_cos  <= '0;
            r_mode <= MODE_RESET;
            r_leap <= '0;
            r_cnt  <= '0;
            r_fast <= 1'b0;
            r_slow <= 1'b0;
        end else begin
            r_time  <= n_time;
            r_alarm <= n_alarm;
            r_cos   <= n_cos;
            r_mode  <= n_mode;
            r_leap  <= n_leap;
            r_cnt   <= n_cnt;
            r_fast  <= n_fast;
            r_slow  <= n_slow;
        end
    end

    `BCR_ASSERT(a_cnt_range, r_cnt <= P_FULL)
    `BCR_ASSERT(a_slow_rise_wraps, $rose(r_slow) |-> (r_cnt == 5'd0))
    `BCR_ASSERT(a_fast_only_on_tick, !$stable(r_fast) |-> $past(fire && r_in_op == OP_TICK))
    `BCR_ASSERT_NEXT(a_result_follows, fire, r_out_valid && r_out_fast == r_fast)

endmodule
